// File: rtl/bayes_weight_update_normalize_unit_defines.svh
// ----------------------------------------------------------------------------
// bayes_weight_update_normalize_unit_defines
// Assertion macros for the particle weight update and normalisation unit.
// ----------------------------------------------------------------------------
`ifndef BAYES_WEIGHT_UPDATE_NORMALIZE_UNIT_DEFINES_SVH
`define BAYES_WEIGHT_UPDATE_NORMALIZE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, switched off while reset is high
`define BWUN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bwun assertion failed");
// checked property that also covers the reset cycles
`define BWUN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bwun assertion failed");
`else
`define BWUN_ASSERT(lbl, clk, rst, prop)
`define BWUN_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/bwun_pkg.sv
// ----------------------------------------------------------------------------
// bwun_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bwun_pkg;

   localparam int WEIGHT_W  = 40;
   localparam int LIK_W     = 32;
   localparam int SUM_W     = 46;
   localparam int INDEX_W   = 6;
   localparam int CFG_W     = 7;
   localparam int KIND_W    = 2;
   localparam int DIV_STEPS = 40;
   localparam int STEP_W    = 6;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic RES_DONE = 1'b0;
   localparam logic RES_READ = 1'b1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
   localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OUT,
      ST_UPD_MUL,
      ST_UPD_SAT,
      ST_UPD_SUM,
      ST_NORM_CHECK,
      ST_NORM_RD,
      ST_NORM_LOAD,
      ST_NORM_DIV,
      ST_NORM_WB,
      ST_DONE_OUT
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic rd_req;
      logic rd_norm;
      logic mul;
      logic sat_wr;
      logic sum_add;
      logic norm_clear;
      logic div_init;
      logic div_step;
      logic norm_wr;
      logic out_read;
      logic out_done;
   } cmd_type;

   typedef struct packed {
      logic req_in_range;
      logic upd_active;
      logic upd_last;
      logic sum_zero;
      logic div_ovf;
      logic div_last;
      logic norm_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/bwun_ctrl.sv
// ----------------------------------------------------------------------------
// bwun_ctrl
// Controller: sequences loads, reads, updates and the normalisation pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bwun_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [bwun_pkg::KIND_W-1:0] req_kind,
   output logic                            req_stall,
   input  wire bwun_pkg::status_type       sts,
   output bwun_pkg::cmd_type               cmd
);
   import bwun_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_READ:   state_in = ST_RD_OUT;
                  KIND_UPDATE: if (sts.upd_active) state_in = ST_UPD_MUL;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_OUT:     if (sts.out_free) state_in = ST_IDLE;
         ST_UPD_MUL:    state_in = ST_UPD_SAT;
         ST_UPD_SAT:    state_in = ST_UPD_SUM;
         ST_UPD_SUM:    state_in = sts.upd_last ? ST_NORM_CHECK : ST_IDLE;
         ST_NORM_CHECK: state_in = sts.sum_zero ? ST_DONE_OUT : ST_NORM_RD;
         ST_NORM_RD:    state_in = ST_NORM_LOAD;
         ST_NORM_LOAD:  state_in = sts.div_ovf ? ST_NORM_WB : ST_NORM_DIV;
         ST_NORM_DIV:   if (sts.div_last) state_in = ST_NORM_WB;
         ST_NORM_WB:    state_in = sts.norm_last ? ST_DONE_OUT : ST_NORM_RD;
         ST_DONE_OUT:   if (sts.out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_LOAD:   cmd.load_wr = sts.req_in_range;
                  KIND_READ:   cmd.rd_req  = 1'b1;
                  KIND_UPDATE: cmd.rd_req  = sts.upd_active;
                  default:     cmd.rd_req  = 1'b0;
               endcase
            end
         end
         ST_RD_OUT:     cmd.out_read   = sts.out_free;
         ST_UPD_MUL:    cmd.mul        = 1'b1;
         ST_UPD_SAT:    cmd.sat_wr     = 1'b1;
         ST_UPD_SUM:    cmd.sum_add    = 1'b1;
         ST_NORM_CHECK: cmd.norm_clear = 1'b1;
         ST_NORM_RD:    cmd.rd_norm    = 1'b1;
         ST_NORM_LOAD:  cmd.div_init   = 1'b1;
         ST_NORM_DIV:   cmd.div_step   = 1'b1;
         ST_NORM_WB:    cmd.norm_wr    = 1'b1;
         ST_DONE_OUT:   cmd.out_done   = sts.out_free;
         default:       cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/bwun_datapath.sv
// ----------------------------------------------------------------------------
// bwun_datapath
// Weight memory, product and sum path, restoring divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bwun_datapath #(
   parameter int PARTICLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bwun_pkg::INDEX_W-1:0]  req_index,
   input  wire logic [bwun_pkg::WEIGHT_W-1:0] req_prior_weight,
   input  wire logic [bwun_pkg::LIK_W-1:0]    req_likelihood,
   input  wire logic                          csr_valid,
   input  wire logic [bwun_pkg::CFG_W-1:0]    csr_particle_count,
   input  wire bwun_pkg::cmd_type             cmd,
   output bwun_pkg::status_type               sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic [bwun_pkg::WEIGHT_W-1:0]      rsp_weight,
   output logic                               rsp_sum_zero,
   output logic                               rsp_saturated
);
   import bwun_pkg::*;

   localparam int AW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int CNT_W = $clog2(PARTICLES + 1);
   localparam logic [CFG_W-1:0] PCOUNT = CFG_W'(PARTICLES);

   // weight store
   logic [WEIGHT_W-1:0] weight_mem [PARTICLES];
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [WEIGHT_W-1:0] mem_wdata;
   logic [WEIGHT_W-1:0] rdata_ff;

   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [AW-1:0]       idx_ff,       idx_in;
   logic [LIK_W-1:0]    lik_ff,       lik_in;
   logic                in_range_ff,  in_range_in;
   logic [63:0]         prod_lo_ff,   prod_lo_in;
   logic [39:0]         prod_hi_ff,   prod_hi_in;
   logic [WEIGHT_W-1:0] new_w_ff,     new_w_in;
   logic [SUM_W-1:0]    sum_ff,       sum_in;
   logic                sat_seen_ff,  sat_seen_in;
   logic [AW-1:0]       norm_idx_ff,  norm_idx_in;
   logic [SUM_W-1:0]    rem_ff,       rem_in;
   logic [WEIGHT_W-1:0] dsh_ff,       dsh_in;
   logic [WEIGHT_W-1:0] quo_ff,       quo_in;
   logic [STEP_W-1:0]   step_ff,      step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff,  rsp_kind_in;
   logic [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic                rsp_zero_ff,  rsp_zero_in;
   logic                rsp_sat_ff,   rsp_sat_in;

   logic [56:0]         prod_sum;
   logic                prod_ovf;
   logic [WEIGHT_W-1:0] prod_sat;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W:0]      rem_wide;
   logic [SUM_W:0]      rem_diff;
   logic                rem_ge;
   logic [CFG_W-1:0]    csr_clamped;

   // Q8.32 x Q16.16 >> 16, upper weight byte handled by its own small product
   assign prod_sum = {1'b0, prod_hi_ff, 16'b0} + {9'b0, prod_lo_ff[63:16]};
   assign prod_ovf = |prod_sum[56:WEIGHT_W];
   assign prod_sat = prod_ovf ? WEIGHT_MAX : prod_sum[WEIGHT_W-1:0];

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(new_w_ff);

   // one quotient bit per cycle, remainder stays below the sum
   assign rem_wide = {rem_ff, dsh_ff[WEIGHT_W-1]};
   assign rem_ge   = (rem_wide >= {1'b0, sum_ff});
   assign rem_diff = rem_wide - {1'b0, sum_ff};

   always_comb begin
      if (csr_particle_count == '0) begin
         csr_clamped = CFG_W'(1);
      end else if (csr_particle_count > PCOUNT) begin
         csr_clamped = PCOUNT;
      end else begin
         csr_clamped = csr_particle_count;
      end
   end

   // status towards the controller
   always_comb begin
      sts.req_in_range = ({1'b0, req_index} < PCOUNT);
      sts.upd_active   = ({1'b0, req_index} < CFG_W'(count_ff));
      sts.upd_last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      sts.sum_zero     = (sum_ff == '0);
      sts.div_ovf      = ((SUM_W+8)'(rdata_ff) >= {sum_ff, 8'b0});
      sts.div_last     = (step_ff == STEP_W'(DIV_STEPS - 1));
      sts.norm_last    = ((CNT_W'(norm_idx_ff) + CNT_W'(1)) == count_ff);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // memory port selection
   always_comb begin
      mem_re    = cmd.rd_req || cmd.rd_norm;
      mem_raddr = cmd.rd_norm ? norm_idx_ff : req_index[AW-1:0];
      mem_we    = cmd.load_wr || cmd.sat_wr || cmd.norm_wr;
      mem_waddr = req_index[AW-1:0];
      mem_wdata = req_prior_weight;
      if (cmd.sat_wr) begin
         mem_waddr = idx_ff;
         mem_wdata = prod_sat;
      end else if (cmd.norm_wr) begin
         mem_waddr = norm_idx_ff;
         mem_wdata = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= weight_mem[mem_raddr];
      end
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      lik_in        = lik_ff;
      in_range_in   = in_range_ff;
      prod_lo_in    = prod_lo_ff;
      prod_hi_in    = prod_hi_ff;
      new_w_in      = new_w_ff;
      sum_in        = sum_ff;
      sat_seen_in   = sat_seen_ff;
      norm_idx_in   = norm_idx_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_zero_in   = rsp_zero_ff;
      rsp_sat_in    = rsp_sat_ff;

      if (csr_valid) begin
         count_in = CNT_W'(csr_clamped);
      end
      if (cmd.rd_req) begin
         idx_in      = req_index[AW-1:0];
         lik_in      = req_likelihood;
         in_range_in = sts.req_in_range;
      end
      if (cmd.mul) begin
         prod_lo_in = {32'b0, rdata_ff[31:0]} * {32'b0, lik_ff};
         prod_hi_in = {32'b0, rdata_ff[WEIGHT_W-1:32]} * {8'b0, lik_ff};
      end
      if (cmd.sat_wr) begin
         new_w_in    = prod_sat;
         sat_seen_in = sat_seen_ff || prod_ovf;
      end
      if (cmd.sum_add) begin
         sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
      if (cmd.norm_clear) begin
         norm_idx_in = '0;
      end
      if (cmd.div_init) begin
         rem_in  = SUM_W'(rdata_ff[WEIGHT_W-1:8]);
         dsh_in  = {rdata_ff[7:0], 32'b0};
         quo_in  = sts.div_ovf ? WEIGHT_MAX : '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         rem_in  = rem_ge ? rem_diff[SUM_W-1:0] : rem_wide[SUM_W-1:0];
         dsh_in  = {dsh_ff[WEIGHT_W-2:0], 1'b0};
         quo_in  = {quo_ff[WEIGHT_W-2:0], rem_ge};
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.norm_wr) begin
         norm_idx_in = norm_idx_ff + AW'(1);
      end
      if (cmd.out_read) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = RES_READ;
         rsp_weight_in = in_range_ff ? rdata_ff : '0;
         rsp_zero_in   = 1'b0;
         rsp_sat_in    = 1'b0;
      end
      if (cmd.out_done) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = RES_DONE;
         rsp_weight_in = '0;
         rsp_zero_in   = sts.sum_zero;
         rsp_sat_in    = sat_seen_ff;
         sum_in        = '0;
         sat_seen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(PARTICLES);
         sum_ff       <= '0;
         sat_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sat_seen_ff  <= sat_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      lik_ff        <= lik_in;
      in_range_ff   <= in_range_in;
      prod_lo_ff    <= prod_lo_in;
      prod_hi_ff    <= prod_hi_in;
      new_w_ff      <= new_w_in;
      norm_idx_ff   <= norm_idx_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_zero_ff   <= rsp_zero_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_weight      = rsp_weight_ff;
   assign rsp_sum_zero    = rsp_zero_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

`default_nettype wire

// File: rtl/bayes_weight_update_normalize_unit.sv
// ----------------------------------------------------------------------------
// bayes_weight_update_normalize_unit
// Particle weight store with likelihood update and normalisation by the sum.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   kind, index, prior_weight, likelihood
//   rsp      out        rsp_valid/rsp_stall   result_kind, weight, sum_zero, saturated
//   csr      in         csr_valid/csr_ready   particle_count
//
// load: a memory write while idle; read: a memory read, then the result register;
// update: a memory read, then the multiply, saturate and accumulate steps around the weight memory.
// the last active update then normalises each active weight: read, divider load, divide, write back,
// with no divide for a quotient that saturates; the restoring divider gives one quotient bit per cycle.
// reset is synchronous and needs no clearing pass; weights are undefined until loaded.
// a stalled result is held in the output register; new loads are still taken.
`default_nettype none

`include "bayes_weight_update_normalize_unit_defines.svh"

module bayes_weight_update_normalize_unit #(
   parameter int PARTICLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bwun_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [bwun_pkg::INDEX_W-1:0]  req_index,
   input  wire logic [bwun_pkg::WEIGHT_W-1:0] req_prior_weight,
   input  wire logic [bwun_pkg::LIK_W-1:0]    req_likelihood,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic [bwun_pkg::WEIGHT_W-1:0]      rsp_weight,
   output logic                               rsp_sum_zero,
   output logic                               rsp_saturated,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bwun_pkg::CFG_W-1:0]    csr_particle_count
);
   import bwun_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // the user must write registers only while idle; the block itself does not enforce it
   assign csr_ready = 1'b1;

   bwun_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bwun_datapath #(
      .PARTICLES (PARTICLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_index          (req_index),
      .req_prior_weight   (req_prior_weight),
      .req_likelihood     (req_likelihood),
      .csr_valid          (csr_valid && csr_ready),
      .csr_particle_count (csr_particle_count),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_weight         (rsp_weight),
      .rsp_sum_zero       (rsp_sum_zero),
      .rsp_saturated      (rsp_saturated)
   );

   `BWUN_ASSERT_ALWAYS(a_rsp_clear_after_reset, clock, reset |=> !rsp_valid)
   `BWUN_ASSERT(a_load_keeps_taking, clock, reset, req_valid && !req_stall && req_kind == KIND_LOAD |=> !req_stall)
   `BWUN_ASSERT(a_read_blocks_input, clock, reset, req_valid && !req_stall && req_kind == KIND_READ |=> req_stall)
   `BWUN_ASSERT(a_done_has_no_weight, clock, reset, rsp_valid && rsp_result_kind == RES_DONE |-> rsp_weight == '0)
   `BWUN_ASSERT(a_read_has_no_flags, clock, reset, rsp_valid && rsp_result_kind == RES_READ |-> !rsp_sum_zero && !rsp_saturated)

endmodule

`default_nettype wire
